>>> hw/rtl/pwnd_pkg.sv
// Shared types, constants and lookup functions for the pulse width nibble deframer.
package pwnd_pkg;

   localparam int PULSE_W = 12;
   localparam int OFFSET_W = 7;
   localparam int POS_W = 5;
   localparam int LEN_W = 3;
   localparam int NIB_W = 4;
   localparam int SYM_W = 5;
   localparam int BYTE_W = 8;

   localparam int MAX_DATA_BYTES_DEF = 5;

   localparam logic [POS_W-1:0] POS_IDLE = 5'd31;
   localparam logic [POS_W-1:0] POS_START = 5'd0;
   localparam logic [POS_W-1:0] POS_FIRST = 5'd1;
   localparam logic [POS_W-1:0] POS_LIMIT = 5'd16;

   localparam logic [PULSE_W-1:0] SYNC_LOW = 12'd750;
   localparam logic [PULSE_W-1:0] SYNC_HIGH = 12'd850;
   localparam logic [PULSE_W-1:0] SYNC_CENTER = 12'd800;
   localparam logic [PULSE_W-1:0] ZERO_WIDTH = 12'd1000;

   // Quantizer scale: (d * 31 + 500) / 1000, division done by reciprocal.
   localparam int SCALE_ROUND = 500;
   localparam int RECIP_SHIFT = 27;
   localparam logic [17:0] RECIP_1000 = 18'd134218;

   typedef struct packed {
      logic              is_sync;
      logic              clk;
      logic [NIB_W-1:0]  nib;
   } symbol_type;

   function automatic logic [LEN_W-1:0] length_by_id(input logic [NIB_W-1:0] id);
      logic [LEN_W-1:0] len;
      unique case (id)
         4'h0: len = 3'd1;
         4'h1: len = 3'd2;
         4'h2: len = 3'd4;
         4'h3: len = 3'd4;
         4'hF: len = 3'd5;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // CRC-4, polynomial x^4 + x + 1, one nibble per step.
   function automatic logic [NIB_W-1:0] crc4_next(input logic [NIB_W-1:0] crc,
                                                   input logic [NIB_W-1:0] nib);
      logic [NIB_W-1:0] res;
      unique case (crc ^ nib)
         4'h0: res = 4'h0;
         4'h1: res = 4'h3;
         4'h2: res = 4'h6;
         4'h3: res = 4'h5;
         4'h4: res = 4'hC;
         4'h5: res = 4'hF;
         4'h6: res = 4'hA;
         4'h7: res = 4'h9;
         4'h8: res = 4'hB;
         4'h9: res = 4'h8;
         4'hA: res = 4'hD;
         4'hB: res = 4'hE;
         4'hC: res = 4'h7;
         4'hD: res = 4'h4;
         4'hE: res = 4'h1;
         default: res = 4'h2;
      endcase
      return res;
   endfunction

endpackage

>>> hw/rtl/pulse_width_nibble_deframer.sv
// Top level of the pulse width nibble deframer.
// An accepted word waits in the input register; its result is registered into the
// result register when the result side is free. Throughput: one pulse word per cycle
// while the result side does not stall, set by the single registered decode stage.
// Reset (synchronous, active high) empties both stages, sets the frame position to
// idle and clears the offset, CRC, clock bit, id, length and stored payload bytes.
module pulse_width_nibble_deframer #(
   parameter int MAX_DATA_BYTES = pwnd_pkg::MAX_DATA_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [pwnd_pkg::PULSE_W-1:0] req_pulse_width,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_frame_valid,
   output logic                         rsp_link_seen,
   output logic [pwnd_pkg::NIB_W-1:0]   rsp_frame_id,
   output logic [pwnd_pkg::LEN_W-1:0]   rsp_data_length,
   output logic [pwnd_pkg::BYTE_W-1:0]  rsp_byte_zero,
   output logic [pwnd_pkg::BYTE_W-1:0]  rsp_byte_one,
   output logic [pwnd_pkg::BYTE_W-1:0]  rsp_byte_two,
   output logic [pwnd_pkg::BYTE_W-1:0]  rsp_byte_three,
   output logic [pwnd_pkg::BYTE_W-1:0]  rsp_byte_four
);
   import pwnd_pkg::*;

   localparam int IDX_W = $clog2(MAX_DATA_BYTES);
   localparam int OUT_BYTES = 5;

   // Input register stage.
   logic               in_valid_ff, in_valid_in;
   logic [PULSE_W-1:0] in_width_ff;

   // Frame state.
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic                       prev_clk_ff, prev_clk_in;
   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic [LEN_W-1:0]           exp_len_ff, exp_len_in;
   logic [NIB_W-1:0]           crc_ff, crc_in;
   logic [BYTE_W-1:0]          pending_ff, pending_in;
   logic [NIB_W-1:0]           id_ff, id_in;
   logic [BYTE_W-1:0]          store_ff [MAX_DATA_BYTES];

   // Result register stage.
   logic                  out_valid_ff, out_valid_in;
   logic                  out_frame_ff, out_frame_in;
   logic                  out_link_ff, out_link_in;
   logic [NIB_W-1:0]      out_id_ff, out_id_in;
   logic [LEN_W-1:0]      out_len_ff, out_len_in;
   logic [BYTE_W-1:0]     out_bytes_ff [OUT_BYTES];
   logic [BYTE_W-1:0]     out_bytes_in [OUT_BYTES];

   logic              advance;
   logic              fire;
   symbol_type        symbol;
   logic [PULSE_W-1:0] sync_offset_full;
   logic [NIB_W-1:0]  crc_fed;
   logic [POS_W-1:0]  pos_minus;
   logic [POS_W-1:0]  pos_plus;
   logic              store_we;
   logic [IDX_W-1:0]  store_idx;
   logic [BYTE_W-1:0] store_data;

   // The decode stage moves forward whenever the result register is empty or being
   // taken, so a waiting result never blocks a new word by more than that one slot.
   assign advance = !out_valid_ff || rsp_ready;
   assign fire = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   pwnd_quant u_quant (
      .width  (in_width_ff),
      .offset (offset_ff),
      .symbol (symbol)
   );

   assign sync_offset_full = in_width_ff - SYNC_CENTER;
   assign crc_fed = crc4_next(crc_ff, symbol.nib);
   assign pos_minus = pos_ff - POS_FIRST;
   assign pos_plus = pos_ff + POS_FIRST;
   assign store_idx = pos_minus[IDX_W-1:0];

   // Frame sequencer. A sync pulse opens a frame; the first clock-0 symbol is the id;
   // later symbols count only when their clock bit toggles. A clock-1 symbol is either
   // a high nibble or, once all bytes are in, the CRC check nibble.
   always_comb begin
      pos_in = pos_ff;
      prev_clk_in = prev_clk_ff;
      offset_in = offset_ff;
      exp_len_in = exp_len_ff;
      crc_in = crc_ff;
      pending_in = pending_ff;
      id_in = id_ff;
      store_we = 1'b0;
      store_data = pending_ff | {4'h0, symbol.nib};
      out_frame_in = 1'b0;
      out_link_in = 1'b0;
      out_id_in = '0;
      out_len_in = '0;
      for (int k = 0; k < OUT_BYTES; k++) begin
         out_bytes_in[k] = '0;
      end

      if (symbol.is_sync) begin
         prev_clk_in = 1'b0;
         pos_in = POS_START;
         offset_in = sync_offset_full[OFFSET_W-1:0];
         crc_in = '0;
      end else if (pos_ff == POS_START && !symbol.clk) begin
         id_in = symbol.nib;
         exp_len_in = length_by_id(symbol.nib);
         crc_in = crc_fed;
         prev_clk_in = 1'b0;
         pos_in = POS_FIRST;
      end else if (symbol.clk != prev_clk_ff && pos_ff != POS_IDLE && pos_ff != POS_START) begin
         out_link_in = 1'b1;
         crc_in = crc_fed;
         prev_clk_in = symbol.clk;
         if (symbol.clk) begin
            if (pos_ff > POS_W'(exp_len_ff)) begin
               // Check nibble: emit the frame on a match, drop it otherwise.
               if (crc_ff == symbol.nib) begin
                  out_frame_in = 1'b1;
                  out_id_in = id_ff;
                  out_len_in = exp_len_ff;
                  for (int k = 0; k < OUT_BYTES; k++) begin
                     if (LEN_W'(k) < exp_len_ff) begin
                        out_bytes_in[k] = store_ff[k];
                     end
                  end
               end
               pos_in = POS_IDLE;
            end else begin
               pending_in = {symbol.nib, 4'h0};
            end
         end else begin
            pending_in = store_data;
            store_we = (pos_minus < POS_W'(MAX_DATA_BYTES));
            pos_in = (pos_plus >= POS_LIMIT) ? POS_IDLE : pos_plus;
         end
      end
   end

   assign out_valid_in = fire || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff <= POS_IDLE;
         prev_clk_ff <= 1'b0;
         offset_ff <= '0;
         exp_len_ff <= '0;
         crc_ff <= '0;
         pending_ff <= '0;
         id_ff <= '0;
         for (int k = 0; k < MAX_DATA_BYTES; k++) begin
            store_ff[k] <= '0;
         end
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            pos_ff <= pos_in;
            prev_clk_ff <= prev_clk_in;
            offset_ff <= offset_in;
            exp_len_ff <= exp_len_in;
            crc_ff <= crc_in;
            pending_ff <= pending_in;
            id_ff <= id_in;
            if (store_we) begin
               store_ff[store_idx] <= store_data;
            end
         end
      end
   end

   // Payload registers: the input word and the result fields need no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_width_ff <= req_pulse_width;
      end
      if (fire) begin
         out_frame_ff <= out_frame_in;
         out_link_ff <= out_link_in;
         out_id_ff <= out_id_in;
         out_len_ff <= out_len_in;
         for (int k = 0; k < OUT_BYTES; k++) begin
            out_bytes_ff[k] <= out_bytes_in[k];
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_frame_valid = out_frame_ff;
   assign rsp_link_seen = out_link_ff;
   assign rsp_frame_id = out_id_ff;
   assign rsp_data_length = out_len_ff;
   assign rsp_byte_zero = out_bytes_ff[0];
   assign rsp_byte_one = out_bytes_ff[1];
   assign rsp_byte_two = out_bytes_ff[2];
   assign rsp_byte_three = out_bytes_ff[3];
   assign rsp_byte_four = out_bytes_ff[4];

`ifndef SYNTHESIS
   // A completed frame always comes from a toggling data symbol.
   a_frame_has_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_valid |-> rsp_link_seen)
      else $error("frame reported without link activity");

   // Without a completed frame the id and length fields are zero.
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_valid |-> rsp_frame_id == '0 && rsp_data_length == '0)
      else $error("id or length set on a result without a frame");

   // The last byte field is zero when the frame is shorter than five bytes.
   a_short_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_length < 3'd5 |-> rsp_byte_four == '0)
      else $error("byte past the frame length is not zero");

   // The frame position never passes the byte limit without returning to idle.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT || pos_ff == POS_IDLE)
      else $error("frame position out of range");

   // A decoded word never overwrites a result that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_frame_ff))
      else $error("result register changed while stalled");
`endif

endmodule

>>> hw/rtl/pwnd_quant.sv
// Pulse width quantizer: sync detection and Gray-coded symbol extraction.
module pwnd_quant (
   input  logic [pwnd_pkg::PULSE_W-1:0]         width,
   input  logic signed [pwnd_pkg::OFFSET_W-1:0] offset,
   output pwnd_pkg::symbol_type                 symbol
);
   import pwnd_pkg::*;

   logic signed [13:0] diff;
   logic signed [18:0] diff_ext;
   logic signed [18:0] scaled;
   logic               negative;
   logic [18:0]        magnitude_full;
   logic [16:0]        magnitude;
   logic [34:0]        product;
   logic [SYM_W-1:0]   quot_low;
   logic [SYM_W-1:0]   sym;

   // Width minus the nominal zero point and the calibration offset.
   assign diff = $signed({2'b00, width}) - $signed({2'b00, ZERO_WIDTH})
                 - 14'(offset);
   assign diff_ext = 19'(diff);
   assign scaled = (diff_ext <<< 5) - diff_ext + 19'sd500;

   // Divide by 1000 toward zero: work on the magnitude, restore the sign after.
   assign negative = scaled[18];
   assign magnitude_full = negative ? 19'(-scaled) : 19'(scaled);
   assign magnitude = magnitude_full[16:0];
   assign product = 35'(magnitude) * 35'(RECIP_1000);
   assign quot_low = product[RECIP_SHIFT +: SYM_W];
   assign sym = negative ? SYM_W'(5'd0 - quot_low) : quot_low;

   assign symbol.is_sync = (width > SYNC_LOW) && (width < SYNC_HIGH);
   assign symbol.clk = sym[SYM_W-1];
   assign symbol.nib = sym[NIB_W-1:0] ^ sym[SYM_W-1:1];

endmodule
